// ===== src/iwrs_pkg.sv =====
// Shared types and constants for the iris-wipe row span generator.
// No dependencies; every other file refers to this package by scoped names.
package iwrs_pkg;

    // Field widths fixed by the register map and the item formats.
    localparam int FRM_W = 12;   // frame index and frame total
    localparam int ROW_W = 12;   // row number
    localparam int DIM_W = 13;   // radii, screen sizes, span results

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_RADIUS_START  = 3'd2,
        CFG_RADIUS_END    = 3'd3,
        CFG_FRAME_TOTAL   = 3'd4,
        CFG_FILL_COLOR    = 3'd5,
        CFG_SCREEN_WIDTH  = 3'd6,
        CFG_SCREEN_HEIGHT = 3'd7
    } t_cfg_idx;

    // Register reset values.
    localparam int RST_CENTER_X     = 320;
    localparam int RST_CENTER_Y     = 240;
    localparam int RST_RADIUS_START = 683;
    localparam int RST_RADIUS_END   = 60;
    localparam int RST_FRAME_TOTAL  = 20;
    localparam int RST_SCREEN_W     = 640;
    localparam int RST_SCREEN_H     = 480;

    // Magnitude of (radius_end - radius_start) * frame + frame_total / 2 stays below 2**25.
    localparam int NUM_W = 25;

    // The radius is saturated at 2**17. Beyond that the circle edge lies far outside
    // any reachable column and row for every center, so the spans do not change.
    localparam int RAD_W = 18;
    localparam logic [RAD_W-1:0] RAD_CAP = 18'h20000;

    // Square root: 18 result bits over a 36-bit radicand.
    localparam int SQ_W = 18;
    localparam int RD_W = 2 * SQ_W;

    // Queue between the radius front end and the span back end.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // One row query after its radius has been resolved.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [RAD_W-1:0] radius;
    } t_mid;

endpackage

// ===== src/iwrs_in_if.sv =====
// Row query channel: frame index and row number with a valid/ready handshake.
// Depends on iwrs_pkg for the field widths.
interface iwrs_in_if;
    logic                       valid;
    logic                       ready;
    logic [iwrs_pkg::FRM_W-1:0] frame_index;
    logic [iwrs_pkg::ROW_W-1:0] row;

    modport source(output valid, frame_index, row, input ready);
    modport sink(input valid, frame_index, row, output ready);
endinterface

// ===== src/iwrs_out_if.sv =====
// Span result channel: left span length and right span start with valid/ready.
// Depends on iwrs_pkg for the field widths.
interface iwrs_out_if;
    logic                       valid;
    logic                       ready;
    logic [iwrs_pkg::DIM_W-1:0] left_count;
    logic [iwrs_pkg::DIM_W-1:0] right_start;

    modport source(output valid, left_count, right_start, input ready);
    modport sink(input valid, left_count, right_start, output ready);
endinterface

// ===== src/iris_wipe_row_spans.sv =====
// Iris-wipe row span generator, top level; uses iwrs_pkg, the channel interfaces,
// iwrs_front, iwrs_fifo and iwrs_back.
// A query passes through the front end, the queue and the back end, in that order.
// Throughput: one query per cycle while the output side is not stalled, set by the fully
// pipelined divider and square root.
// Reset (synchronous, active low) empties every stage and the queue and loads the
// register defaults; no clearing pass is needed.
module iris_wipe_row_spans #(
    parameter int COORD_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    iwrs_in_if.sink                         i_item,
    iwrs_out_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [iwrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [iwrs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CB = COORD_BITS;
    localparam int DW = iwrs_pkg::DIM_W;
    localparam int FW = iwrs_pkg::FRM_W;

    // Configuration registers. The user must change them only while the block is idle; the
    // block does not enforce this. The pipelines read them directly, with no per-transaction copies.
    // The fill color does not affect the span geometry, so its writes are dropped.
    logic signed [CB-1:0] r_cx;
    logic signed [CB-1:0] r_cy;
    logic [DW-1:0]        r_rs;
    logic [DW-1:0]        r_re;
    logic [FW-1:0]        r_ft;
    logic [DW-1:0]        r_w;
    logic [DW-1:0]        r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= CB'(iwrs_pkg::RST_CENTER_X);
            r_cy <= CB'(iwrs_pkg::RST_CENTER_Y);
            r_rs <= DW'(iwrs_pkg::RST_RADIUS_START);
            r_re <= DW'(iwrs_pkg::RST_RADIUS_END);
            r_ft <= FW'(iwrs_pkg::RST_FRAME_TOTAL);
            r_w  <= DW'(iwrs_pkg::RST_SCREEN_W);
            r_h  <= DW'(iwrs_pkg::RST_SCREEN_H);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iwrs_pkg::CFG_CENTER_X:      r_cx <= $signed(i_cfg_data[CB-1:0]);
                iwrs_pkg::CFG_CENTER_Y:      r_cy <= $signed(i_cfg_data[CB-1:0]);
                iwrs_pkg::CFG_RADIUS_START:  r_rs <= i_cfg_data[DW-1:0];
                iwrs_pkg::CFG_RADIUS_END:    r_re <= i_cfg_data[DW-1:0];
                iwrs_pkg::CFG_FRAME_TOTAL:   r_ft <= i_cfg_data[FW-1:0];
                iwrs_pkg::CFG_FILL_COLOR:    ;
                iwrs_pkg::CFG_SCREEN_WIDTH:  r_w  <= i_cfg_data[DW-1:0];
                iwrs_pkg::CFG_SCREEN_HEIGHT: r_h  <= i_cfg_data[DW-1:0];
                default:                     ;
            endcase
        end
    end

    // Front end: one multiplier stage, the rounding add, then a 25-stage restoring
    // divider that yields the radius for the transaction's frame.
    logic           f_push;
    iwrs_pkg::t_mid f_data;
    logic           q_full;
    logic           q_vld;
    iwrs_pkg::t_mid q_data;
    logic           b_pop;

    iwrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_item.valid),
        .o_rdy       (i_item.ready),
        .i_frame     (i_item.frame_index),
        .i_row       (i_item.row),
        .i_rs        (r_rs),
        .i_re        (r_re),
        .i_ft        (r_ft),
        .o_push      (f_push),
        .o_push_data (f_data),
        .i_full      (q_full)
    );

    // The queue lets the front end keep taking transactions while the output side is stalled,
    // until the queue fills, and lets the back end drain on its own.
    iwrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_data),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_vld   (q_vld),
        .o_data  (q_data)
    );

    // Back end: row classification and squares, an 18-stage square root with
    // rounding, and the output register that holds a result until it is taken.
    iwrs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_data  (q_data),
        .o_pop   (b_pop),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_w     (r_w),
        .i_h     (r_h),
        .o_vld   (o_rsp.valid),
        .i_rdy   (o_rsp.ready),
        .o_left  (o_rsp.left_count),
        .o_right (o_rsp.right_start)
    );

endmodule

// ===== src/iwrs_front.sv =====
// Front end: accepts row queries and resolves the interpolated radius through a
// pipelined restoring divider. Depends on iwrs_pkg.
module iwrs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  logic [iwrs_pkg::FRM_W-1:0] i_frame,
    input  logic [iwrs_pkg::ROW_W-1:0] i_row,
    input  logic [iwrs_pkg::DIM_W-1:0] i_rs,
    input  logic [iwrs_pkg::DIM_W-1:0] i_re,
    input  logic [iwrs_pkg::FRM_W-1:0] i_ft,
    output logic                       o_push,
    output iwrs_pkg::t_mid             o_push_data,
    input  logic                       i_full
);
    localparam int FW = iwrs_pkg::FRM_W;
    localparam int RW = iwrs_pkg::ROW_W;
    localparam int NW = iwrs_pkg::NUM_W;
    localparam int AW = iwrs_pkg::RAD_W;
    localparam int PW = NW + 2;
    localparam int ST = NW;

    logic                 f_adv;
    logic [FW-1:0]        dv;
    logic [FW:0]          cnt;
    logic signed [iwrs_pkg::DIM_W:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] num;
    logic                 num_neg;
    logic [NW-1:0]        num_mag;
    logic signed [NW:0]   quo;
    logic signed [PW-1:0] rsum;
    logic [AW-1:0]        rad;

    logic                 r_a_vld;
    logic signed [PW-1:0] r_a_prod;
    logic [RW-1:0]        r_a_row;

    logic          r_vld [ST+1];
    logic [RW-1:0] r_row [ST+1];
    logic          r_neg [ST+1];
    logic [NW-1:0] r_acc [ST+1];
    logic [FW-1:0] r_rem [ST+1];
    logic [NW-1:0] n_acc [ST+1];
    logic [FW-1:0] n_rem [ST+1];
    logic [FW:0]   dpart [ST+1];
    logic          dge   [ST+1];

    always_comb begin
        // A zero frame total means one step taken at frame one.
        dv   = (i_ft == '0) ? FW'(1) : i_ft;
        cnt  = (i_ft == '0) ? (FW+1)'(1) : {1'b0, i_frame};
        diff = $signed({1'b0, i_re}) - $signed({1'b0, i_rs});
        prod = PW'(diff) * $signed(PW'(cnt));

        num     = r_a_prod + $signed(PW'(dv >> 1));
        num_neg = num[PW-1];
        num_mag = NW'(num_neg ? -num : num);

        n_acc[0] = num_mag;
        n_rem[0] = '0;
        dpart[0] = '0;
        dge[0]   = 1'b0;
        for (int k = 1; k <= ST; k++) begin
            dpart[k] = {r_rem[k-1], r_acc[k-1][NW-1]};
            dge[k]   = dpart[k] >= {1'b0, dv};
            n_rem[k] = FW'(dge[k] ? dpart[k] - {1'b0, dv} : dpart[k]);
            n_acc[k] = {r_acc[k-1][NW-2:0], dge[k]};
        end

        // Truncation toward zero: divide the magnitude, then restore the sign.
        quo  = r_neg[ST] ? -$signed({1'b0, r_acc[ST]}) : $signed({1'b0, r_acc[ST]});
        rsum = $signed(PW'(i_rs)) + PW'(quo);
        if (rsum < PW'(1)) begin
            rad = AW'(1);
        end else if (rsum > $signed(PW'(iwrs_pkg::RAD_CAP))) begin
            rad = iwrs_pkg::RAD_CAP;
        end else begin
            rad = AW'(rsum);
        end
    end

    assign f_adv              = !r_vld[ST] || !i_full;
    assign o_rdy              = f_adv;
    assign o_push             = r_vld[ST] && !i_full;
    assign o_push_data.row    = r_row[ST];
    assign o_push_data.radius = rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            for (int k = 0; k <= ST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (f_adv) begin
            r_a_vld  <= i_vld;
            r_vld[0] <= r_a_vld;
            for (int k = 1; k <= ST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_a_prod <= prod;
            r_a_row  <= i_row;
            r_row[0] <= r_a_row;
            r_neg[0] <= num_neg;
            r_acc[0] <= n_acc[0];
            r_rem[0] <= n_rem[0];
            for (int k = 1; k <= ST; k++) begin
                r_row[k] <= r_row[k-1];
                r_neg[k] <= r_neg[k-1];
                r_acc[k] <= n_acc[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

endmodule

// ===== src/iwrs_fifo.sv =====
// Short show-ahead queue that decouples the radius front end from the span back end.
// Depends on iwrs_pkg for the entry type and depth.
module iwrs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iwrs_pkg::t_mid i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_vld,
    output iwrs_pkg::t_mid o_data
);
    localparam int DP = iwrs_pkg::FIFO_DEPTH;
    localparam int PT = iwrs_pkg::FIFO_PTR_W;

    iwrs_pkg::t_mid r_mem [DP];
    logic [PT-1:0]  r_wr;
    logic [PT-1:0]  r_rd;
    logic [PT:0]    r_cnt;

    assign o_full = r_cnt == (PT+1)'(DP);
    assign o_vld  = r_cnt != '0;
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PT'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PT'(1);
            end
            r_cnt <= r_cnt + (PT+1)'(i_push) - (PT+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != (PT+1)'(DP)))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue read while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_cnt == $past(r_cnt) + (PT+1)'($past(i_push)) - (PT+1)'($past(i_pop))))
        else $error("queue fill count does not follow pushes and pops");
`endif

endmodule

// ===== src/iwrs_back.sv =====
// Back end: classifies each row against the circle, takes a pipelined rounded
// square root of r*r - j*j and forms the two spans. Depends on iwrs_pkg.
module iwrs_back #(
    parameter int COORD_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  iwrs_pkg::t_mid               i_data,
    output logic                         o_pop,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic [iwrs_pkg::DIM_W-1:0]   i_w,
    input  logic [iwrs_pkg::DIM_W-1:0]   i_h,
    output logic                         o_vld,
    input  logic                         i_rdy,
    output logic [iwrs_pkg::DIM_W-1:0]   o_left,
    output logic [iwrs_pkg::DIM_W-1:0]   o_right
);
    localparam int RW = iwrs_pkg::ROW_W;
    localparam int AW = iwrs_pkg::RAD_W;
    localparam int DW = iwrs_pkg::DIM_W;
    localparam int SW = iwrs_pkg::SQ_W;
    localparam int DR = iwrs_pkg::RD_W;
    localparam int XW = SW + 1;
    localparam int CW = ((COORD_BITS > AW) ? COORD_BITS : AW) + 2;

    logic b_adv;

    // Stage 0: item taken from the queue.
    logic          r0_vld;
    logic [RW-1:0] r0_row;
    logic [AW-1:0] r0_rad;

    // Stage 1: squares and row class.
    logic signed [CW-1:0]   j;
    logic signed [2*CW-1:0] jsq;
    logic [DR-1:0]          rr;
    logic signed [CW-1:0]   srow;
    logic signed [CW-1:0]   ctop;
    logic signed [CW-1:0]   cbot;
    logic                   full_t;
    logic                   full_b;
    logic          r1_vld;
    logic [DR-1:0] r1_rr;
    logic [DR-1:0] r1_jj;
    logic          r1_on;
    logic          r1_full;

    // Square root stages; stage 0 holds the radicand.
    logic          s_vld  [SW+1];
    logic          s_on   [SW+1];
    logic          s_full [SW+1];
    logic [DR-1:0] s_acc  [SW+1];
    logic [SW:0]   s_rem  [SW+1];
    logic [SW-1:0] s_root [SW+1];
    logic [DR-1:0] n_acc  [SW+1];
    logic [SW:0]   n_rem  [SW+1];
    logic [SW-1:0] n_root [SW+1];
    logic [SW+2:0] qt     [SW+1];
    logic [SW+2:0] qtrial [SW+1];
    logic          qge    [SW+1];

    // Output stage.
    logic                 rnd;
    logic [XW-1:0]        x;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] lftd;
    logic signed [CW-1:0] rgtd;
    logic signed [CW-1:0] sw;
    logic [DW-1:0]        n_left;
    logic [DW-1:0]        n_right;
    logic                 r_o_vld;
    logic [DW-1:0]        r_left;
    logic [DW-1:0]        r_right;

    assign b_adv = !r_o_vld || i_rdy;
    assign o_pop = i_vld && b_adv;

    always_comb begin
        j      = $signed(CW'(r0_row)) - CW'(i_cy);
        jsq    = (2*CW)'(j) * (2*CW)'(j);
        rr     = DR'(r0_rad) * DR'(r0_rad);
        srow   = $signed(CW'(r0_row));
        ctop   = CW'(i_cy) - $signed(CW'(r0_rad));
        cbot   = CW'(i_cy) + $signed(CW'(r0_rad));
        full_t = !ctop[CW-1] && (srow <= ctop);
        full_b = (cbot < $signed(CW'(i_h))) && (srow >= cbot);

        // Only rows that cross the circle get a real radicand; there |j| < r.
        n_acc[0]  = (r1_on && !r1_full) ? r1_rr - r1_jj : '0;
        n_rem[0]  = '0;
        n_root[0] = '0;
        qt[0]     = '0;
        qtrial[0] = '0;
        qge[0]    = 1'b0;
        for (int k = 1; k <= SW; k++) begin
            qt[k]     = {s_rem[k-1], s_acc[k-1][DR-1 -: 2]};
            qtrial[k] = (SW+3)'({s_root[k-1], 2'b01});
            qge[k]    = qt[k] >= qtrial[k];
            n_rem[k]  = (SW+1)'(qge[k] ? qt[k] - qtrial[k] : qt[k]);
            n_root[k] = {s_root[k-1][SW-2:0], qge[k]};
            n_acc[k]  = {s_acc[k-1][DR-3:0], 2'b00};
        end

        // The remainder is n - s*s; round up when it exceeds s.
        rnd  = s_rem[SW] > (SW+1)'(s_root[SW]);
        x    = XW'(s_root[SW]) + XW'(rnd);
        sx   = $signed(CW'(x));
        lftd = CW'(i_cx) - sx;
        rgtd = CW'(i_cx) + sx;
        sw   = $signed(CW'(i_w));

        if (!s_on[SW]) begin
            n_left  = '0;
            n_right = i_w;
        end else if (s_full[SW]) begin
            n_left  = i_w;
            n_right = i_w;
        end else begin
            if (lftd[CW-1]) begin
                n_left = '0;
            end else if (lftd + CW'(1) > sw) begin
                n_left = i_w;
            end else begin
                n_left = DW'(lftd + CW'(1));
            end
            if (rgtd >= sw) begin
                n_right = i_w;
            end else if (rgtd[CW-1]) begin
                n_right = '0;
            end else begin
                n_right = DW'(rgtd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld  <= 1'b0;
            r1_vld  <= 1'b0;
            r_o_vld <= 1'b0;
            for (int k = 0; k <= SW; k++) begin
                s_vld[k] <= 1'b0;
            end
        end else if (b_adv) begin
            r0_vld   <= i_vld;
            r1_vld   <= r0_vld;
            s_vld[0] <= r1_vld;
            for (int k = 1; k <= SW; k++) begin
                s_vld[k] <= s_vld[k-1];
            end
            r_o_vld <= s_vld[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r0_row    <= i_data.row;
            r0_rad    <= i_data.radius;
            r1_rr     <= rr;
            r1_jj     <= DR'(jsq);
            r1_on     <= {1'b0, r0_row} < i_h;
            r1_full   <= full_t || full_b;
            s_on[0]   <= r1_on;
            s_full[0] <= r1_full;
            s_acc[0]  <= n_acc[0];
            s_rem[0]  <= n_rem[0];
            s_root[0] <= n_root[0];
            for (int k = 1; k <= SW; k++) begin
                s_on[k]   <= s_on[k-1];
                s_full[k] <= s_full[k-1];
                s_acc[k]  <= n_acc[k];
                s_rem[k]  <= n_rem[k];
                s_root[k] <= n_root[k];
            end
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_vld   = r_o_vld;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule
